>>> design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared definitions for the Huffman code bit packer
// Table geometry, item modes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_BITS  = 8;
  localparam int TABLE_DEPTH  = 1 << SYMBOL_BITS;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int ACC_W        = CODE_W + BYTE_W;
  localparam int CODE_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ld_table;  // write one code table entry
    logic ld_enc;    // merge looked-up code with pending bits
    logic ld_flush;  // stage the pending partial byte for output
    logic shift;     // one output byte transferred
    logic finish;    // keep leftover bits as the new pending byte
  } cmd_t;

  typedef struct packed {
    logic has_byte;    // at least one full byte is staged
    logic final_byte;  // the staged byte is the last for this item
  } status_t;

endpackage

>>> design/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: MSB-first Huffman code packer
// Input channel: in_valid/in_stall with mode, symbol, code_word, code_length.
//   A load item writes one table entry (length saturated to the code limit).
//   An encode item reads the table, merges the code with
//   the pending bits and emits every full byte. A flush item emits the
//   pending partial byte padded with zeros. Unused modes are dropped.
// Output channel: out_valid/out_stall with out_byte and last; last marks the
//   final byte caused by an item. The first code bit lands in bit 7.
// Sequencing: one item at a time. An encode goes through the registered
//   table read and the merge register and then emits its output bytes
//   (0 to 4), one byte per transfer; a flush emits at most one byte.
//   While a byte waits under out_stall, it and its last flag hold steady
//   and in_stall stays high.
// Reset: rst clears the table's valid bits, so every entry reads as length
//   zero, and clears the pending byte. No clearing pass is needed; items are
//   taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       mode,
  input  logic [hcbp_pkg::SYMBOL_BITS-1:0] symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]      code_word,
  input  logic [hcbp_pkg::LEN_W-1:0]       code_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]      out_byte,
  output logic                             last
);

  import hcbp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  hcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  hcbp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .symbol      (symbol),
    .code_word   (code_word),
    .code_length (code_length),
    .sts         (sts),
    .out_byte    (out_byte),
    .last        (last)
  );

endmodule

>>> design/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/hcbp_ctrl.sv
// ----------------------------------------------------------------------------
// hcbp_ctrl: controller of the Huffman code bit packer
// Takes one item at a time, sequences the table lookup and steps the datapath
// through the output bytes that the item produces.
// ----------------------------------------------------------------------------
module hcbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  output logic              out_valid,
  input  logic              out_stall,
  output hcbp_pkg::cmd_t    cmd,
  input  hcbp_pkg::status_t sts
);

  import hcbp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (mode)
            MODE_LOAD: begin
              cmd.ld_table = 1'b1;
            end
            MODE_ENCODE: begin
              state_next = ST_READ;
            end
            MODE_FLUSH: begin
              cmd.ld_flush = 1'b1;
              state_next   = ST_EMIT;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.ld_enc = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = sts.has_byte;
        if (sts.has_byte) begin
          cmd.shift = !out_stall;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Only an idle controller may take a new item.
  a_intake_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == ST_IDLE)
    else $error("item taken while busy");

  // Bytes are offered only while emitting.
  a_out_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT)
    else $error("output valid outside emit");

  // An encode item always goes through the table read before emitting.
  a_enc_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && mode == MODE_ENCODE) |=> state == ST_READ)
    else $error("encode skipped table read");

endmodule

>>> design/hcbp_dp.sv
// ----------------------------------------------------------------------------
// hcbp_dp: datapath of the Huffman code bit packer
// Code and length tables, the pending partial byte and a byte-aligned
// accumulator from which output bytes are taken one per transfer.
// ----------------------------------------------------------------------------
module hcbp_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  hcbp_pkg::cmd_t                     cmd,
  input  logic [hcbp_pkg::SYMBOL_BITS-1:0]   symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]        code_word,
  input  logic [hcbp_pkg::LEN_W-1:0]         code_length,
  output hcbp_pkg::status_t                  sts,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               last
);

  import hcbp_pkg::*;

  logic [TABLE_DEPTH-1:0] tbl_valid;
  logic                   rd_valid;
  logic [CODE_W-1:0]      code_rdata;
  logic [LEN_W-1:0]       len_rdata;
  logic [LEN_W-1:0]       len_wdata;
  logic [LEN_W-1:0]       enc_len;
  logic [ACC_W-1:0]       acc;
  logic [LEN_W-1:0]       total;
  logic [BYTE_W-1:0]      pbyte;
  logic [2:0]             pcount;
  logic [CODE_W-1:0]      code_aligned;

  assign len_wdata = (code_length > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : code_length;

  hcbp_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_code_ram (
    .clk   (clk),
    .we    (cmd.ld_table),
    .waddr (symbol),
    .wdata (code_word),
    .raddr (symbol),
    .rdata (code_rdata)
  );

  hcbp_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_DEPTH)) u_len_ram (
    .clk   (clk),
    .we    (cmd.ld_table),
    .waddr (symbol),
    .wdata (len_wdata),
    .raddr (symbol),
    .rdata (len_rdata)
  );

  // An entry never loaded reads as length zero.
  assign enc_len = rd_valid ? len_rdata : '0;

  // Shifting left by (width - length) drops the unused high code bits and
  // leaves the first code bit at the top.
  assign code_aligned = code_rdata << (LEN_W'(CODE_W) - enc_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      rd_valid  <= 1'b0;
      total     <= '0;
      pbyte     <= '0;
      pcount    <= '0;
    end else begin
      rd_valid <= tbl_valid[symbol];
      if (cmd.ld_table) begin
        tbl_valid[symbol] <= 1'b1;
      end
      if (cmd.ld_enc) begin
        total <= LEN_W'(pcount) + enc_len;
      end else if (cmd.ld_flush) begin
        total <= (pcount != 3'd0) ? LEN_W'(BYTE_W) : '0;
      end else if (cmd.shift) begin
        total <= total - LEN_W'(BYTE_W);
      end
      if (cmd.finish) begin
        pbyte  <= acc[ACC_W-1 -: BYTE_W];
        pcount <= total[2:0];
      end
    end
  end

  // The pending bits sit at the top of the accumulator, the new code right
  // below them, and zeros fill the rest.
  always_ff @(posedge clk) begin
    if (cmd.ld_enc) begin
      acc <= {pbyte, {CODE_W{1'b0}}} | ({code_aligned, {BYTE_W{1'b0}}} >> pcount);
    end else if (cmd.ld_flush) begin
      acc <= {pbyte, {CODE_W{1'b0}}};
    end else if (cmd.shift) begin
      acc <= acc << BYTE_W;
    end
  end

  assign sts.has_byte   = total >= LEN_W'(BYTE_W);
  assign sts.final_byte = total < LEN_W'(2 * BYTE_W);
  assign out_byte       = acc[ACC_W-1 -: BYTE_W];
  assign last           = sts.final_byte;

  // Bits of the pending byte below the held count stay zero, so a flush pads
  // with zeros.
  a_pending_pad: assert property (@(posedge clk) disable iff (rst)
    (pbyte & (8'hFF >> pcount)) == 8'h00)
    else $error("pending byte has stray low bits");

  // The accumulator never holds more bits than it can.
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= LEN_W'(ACC_W - 1))
    else $error("bit count out of range");

  // After the final byte of an item is taken, no full byte remains.
  a_final_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift && sts.final_byte) |=> !sts.has_byte)
    else $error("bytes left after final byte");

endmodule
